/* hdl/rbnh_pkg.sv */
// Shared types, constants and helpers for the ray against quad nearest hit block.
`timescale 1ns / 1ps
package rbnh_pkg;

   localparam int CoordW   = 24;
   localparam int CornerW  = 25;
   localparam int HitIdxW  = 10;
   localparam int TBits    = 32;
   localparam int CsrIdxW  = 3;
   localparam longint unsigned DistLimit = 64'd10000000;

   localparam logic [CsrIdxW-1:0] CSR_START_X = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_START_Y = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_DIR_X   = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_DIR_Y   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_LENGTH  = 3'd4;

   typedef struct packed {
      logic signed [CoordW-1:0] start_x;
      logic signed [CoordW-1:0] start_y;
      logic signed [CoordW-1:0] dir_x;
      logic signed [CoordW-1:0] dir_y;
      logic [CoordW-2:0]        ray_length;
   } ray_cfg_type;

   typedef struct packed {
      logic signed [3:0][CornerW-1:0] px;
      logic signed [3:0][CornerW-1:0] py;
      logic                           enabled;
      logic                           last_box;
      logic [HitIdxW-1:0]             idx;
   } quad_type;

   typedef enum logic [3:0] {
      B_IDLE, B_END, B_SETUP, B_CROSS, B_CHECK, B_DIV, B_POS, B_DIST, B_FINISH
   } back_state_type;

   typedef struct packed {
      logic busy;
      logic emit;
   } back_status_type;

   function automatic logic signed [CoordW-1:0] sat24(input logic signed [47:0] v);
      if (v > 48'sd8388607) return 24'sh7FFFFF;
      if (v < -48'sd8388608) return 24'sh800000;
      return v[CoordW-1:0];
   endfunction

endpackage

/* hdl/rbnh_queue.sv */
// Two-word queue between the quad front end and the edge engine.
`timescale 1ns / 1ps
module rbnh_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rbnh_pkg::quad_type push_data,
   output logic              full,
   input  logic              pop,
   output rbnh_pkg::quad_type pop_data,
   output logic              empty
);
   import rbnh_pkg::*;

   quad_type  mem_ff [2];
   logic      wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop) rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

/* hdl/rbnh_front.sv */
// Front end: takes quad words, forms absolute corners and arrival index.
`timescale 1ns / 1ps
module rbnh_front #(
   parameter int MAX_BOXES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [239:0]      req_tdata,
   input  logic              req_tuser,
   input  logic              req_tlast,
   output logic              push,
   output rbnh_pkg::quad_type push_data,
   input  logic              full
);
   import rbnh_pkg::*;

   localparam int CntW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

   logic [CntW-1:0] count_ff, count_in;
   logic [31:0]     count_wide;
   logic signed [CoordW-1:0] off_x, off_y, cx, cy;

   assign req_tready = ~full;
   assign push       = req_tvalid & ~full;
   assign off_x      = req_tdata[8*CoordW +: CoordW];
   assign off_y      = req_tdata[9*CoordW +: CoordW];
   assign count_wide = 32'(count_ff);

   always_comb begin
      push_data          = '0;
      push_data.enabled  = req_tuser;
      push_data.last_box = req_tlast;
      push_data.idx      = count_wide[HitIdxW-1:0];
      for (int k = 0; k < 4; k++) begin
         cx = req_tdata[(2*k)*CoordW +: CoordW];
         cy = req_tdata[(2*k+1)*CoordW +: CoordW];
         push_data.px[k] = CornerW'(off_x) + CornerW'(cx);
         push_data.py[k] = CornerW'(off_y) + CornerW'(cy);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push) begin
         if (req_tlast || count_ff == CntW'(MAX_BOXES - 1)) count_in = '0;
         else count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end
endmodule

/* hdl/rbnh_back.sv */
// Edge engine: sequenced cross products, serial divider, nearest hit tracking.
`timescale 1ns / 1ps
module rbnh_back #(
   parameter int FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rbnh_pkg::ray_cfg_type   cfg,
   input  logic                    q_empty,
   input  rbnh_pkg::quad_type      q_data,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [63:0]             rsp_tdata,
   output logic                    rsp_tuser,
   output rbnh_pkg::back_status_type status
);
   import rbnh_pkg::*;

   localparam longint unsigned LimBase = DistLimit << FRAC_BITS;
   localparam logic [63:0] LimSq = (LimBase >= 64'h1_0000_0000) ? '1 : LimBase * LimBase;

   back_state_type state_ff, state_in;
   logic [5:0] step_ff;
   logic [1:0] edge_ff;
   quad_type   item_ff;

   logic signed [CoordW-1:0] ex_ff, ey_ff;
   logic signed [26:0] rx_ff, ry_ff, wx_ff, wy_ff, ax_ff, ay_ff;
   logic signed [25:0] sx_ff, sy_ff;
   logic signed [53:0] d_ff, nu_ff, nt_ff;
   logic [53:0] rem_ff;
   logic [32:0] tq_ff;
   logic signed [26:0] px_ff, py_ff;
   logic signed [27:0] dx_ff, dy_ff;
   logic [55:0] acc_ff;
   logic [63:0] best_dist_ff;
   logic signed [26:0] best_x_ff, best_y_ff;
   logic [HitIdxW-1:0] best_idx_ff;
   logic any_hit_ff;
   logic out_valid_ff;
   logic [63:0] out_data_ff;
   logic out_hit_ff;

   logic signed [27:0] mul_a;
   logic signed [33:0] mul_b;
   logic signed [61:0] prod_ff;

   logic signed [53:0] dabs, nuabs, ntabs;
   logic miss, one_t, out_free, edge_last, emit;
   logic [54:0] rem2;
   logic rem_ge;
   logic [55:0] dsq;
   logic [1:0] fi;
   logic signed [29:0] shifted;

   assign out_free  = ~out_valid_ff | rsp_tready;
   assign edge_last = (edge_ff == 2'd3);
   assign fi        = edge_ff - 2'd1;
   assign dabs      = d_ff[53] ? -d_ff : d_ff;
   assign nuabs     = d_ff[53] ? -nu_ff : nu_ff;
   assign ntabs     = d_ff[53] ? -nt_ff : nt_ff;
   assign miss      = (d_ff == '0) || nuabs[53] || (nuabs > dabs) || ntabs[53] || (ntabs > dabs);
   assign one_t     = (ntabs == dabs);
   assign rem2      = {rem_ff, 1'b0};
   assign rem_ge    = rem2 >= {1'b0, d_ff};
   assign dsq       = acc_ff + 56'(prod_ff[55:0]);
   assign shifted   = 30'(prod_ff >>> TBits);
   assign emit      = (state_ff == B_FINISH) && item_ff.last_box && out_free;

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_tdata   = out_data_ff;
   assign rsp_tuser   = out_hit_ff;
   assign status.busy = (state_ff != B_IDLE);
   assign status.emit = emit;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         B_END: begin
            mul_a = (step_ff == 6'd0) ? 28'(cfg.dir_x) : 28'(cfg.dir_y);
            mul_b = 34'($signed({1'b0, cfg.ray_length}));
         end
         B_CROSS: begin
            case (step_ff)
               6'd0: begin mul_a = 28'(rx_ff); mul_b = 34'(sy_ff); end
               6'd1: begin mul_a = 28'(ry_ff); mul_b = 34'(sx_ff); end
               6'd2: begin mul_a = 28'(wx_ff); mul_b = 34'(ry_ff); end
               6'd3: begin mul_a = 28'(wy_ff); mul_b = 34'(rx_ff); end
               6'd4: begin mul_a = 28'(wx_ff); mul_b = 34'(sy_ff); end
               6'd5: begin mul_a = 28'(wy_ff); mul_b = 34'(sx_ff); end
               default: ;
            endcase
         end
         B_POS: begin
            mul_a = (step_ff == 6'd0) ? 28'(rx_ff) : 28'(ry_ff);
            mul_b = $signed({1'b0, tq_ff});
         end
         B_DIST: begin
            mul_a = (step_ff == 6'd1) ? dx_ff : dy_ff;
            mul_b = (step_ff == 6'd1) ? 34'(dx_ff) : 34'(dy_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      case (state_ff)
         B_IDLE: if (!q_empty) begin
            q_pop    = 1'b1;
            state_in = q_data.enabled ? B_END : B_FINISH;
         end
         B_END:   if (step_ff == 6'd2) state_in = B_SETUP;
         B_SETUP: state_in = B_CROSS;
         B_CROSS: if (step_ff == 6'd6) state_in = B_CHECK;
         B_CHECK: begin
            if (miss) state_in = edge_last ? B_FINISH : B_SETUP;
            else state_in = one_t ? B_POS : B_DIV;
         end
         B_DIV:   if (step_ff == 6'd31) state_in = B_POS;
         B_POS:   if (step_ff == 6'd2) state_in = B_DIST;
         B_DIST:  if (step_ff == 6'd3) state_in = edge_last ? B_FINISH : B_SETUP;
         B_FINISH: if (!item_ff.last_box || out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= B_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      step_ff <= (state_in != state_ff) ? 6'd0 : step_ff + 6'd1;
      case (state_ff)
         B_IDLE: begin
            item_ff <= q_data;
            edge_ff <= 2'd0;
         end
         B_END: begin
            if (step_ff == 6'd1)
               ex_ff <= sat24(48'(cfg.start_x) + 48'(prod_ff >>> FRAC_BITS));
            if (step_ff == 6'd2)
               ey_ff <= sat24(48'(cfg.start_y) + 48'(prod_ff >>> FRAC_BITS));
         end
         B_SETUP: begin
            ax_ff <= 27'($signed(item_ff.px[fi]));
            ay_ff <= 27'($signed(item_ff.py[fi]));
            rx_ff <= 27'($signed(item_ff.px[edge_ff])) - 27'($signed(item_ff.px[fi]));
            ry_ff <= 27'($signed(item_ff.py[edge_ff])) - 27'($signed(item_ff.py[fi]));
            sx_ff <= 26'(ex_ff) - 26'(cfg.start_x);
            sy_ff <= 26'(ey_ff) - 26'(cfg.start_y);
            wx_ff <= 27'(cfg.start_x) - 27'($signed(item_ff.px[fi]));
            wy_ff <= 27'(cfg.start_y) - 27'($signed(item_ff.py[fi]));
         end
         B_CROSS: begin
            case (step_ff)
               6'd1: d_ff  <= 54'(prod_ff);
               6'd2: d_ff  <= d_ff - 54'(prod_ff);
               6'd3: nu_ff <= 54'(prod_ff);
               6'd4: nu_ff <= nu_ff - 54'(prod_ff);
               6'd5: nt_ff <= 54'(prod_ff);
               6'd6: nt_ff <= nt_ff - 54'(prod_ff);
               default: ;
            endcase
         end
         B_CHECK: begin
            d_ff   <= dabs;
            rem_ff <= ntabs;
            tq_ff  <= one_t ? 33'h1_0000_0000 : 33'd0;
            if (miss) edge_ff <= edge_ff + 2'd1;
         end
         B_DIV: begin
            if (rem_ge) begin
               rem_ff <= 54'(rem2 - {1'b0, d_ff});
               tq_ff  <= {tq_ff[31:0], 1'b1};
            end else begin
               rem_ff <= rem2[53:0];
               tq_ff  <= {tq_ff[31:0], 1'b0};
            end
         end
         B_POS: begin
            if (step_ff == 6'd1) px_ff <= ax_ff + 27'(shifted);
            if (step_ff == 6'd2) py_ff <= ay_ff + 27'(shifted);
         end
         B_DIST: begin
            if (step_ff == 6'd0) begin
               dx_ff <= 28'(px_ff) - 28'(cfg.start_x);
               dy_ff <= 28'(py_ff) - 28'(cfg.start_y);
            end
            if (step_ff == 6'd2) acc_ff <= 56'(prod_ff[55:0]);
            if (step_ff == 6'd3) edge_ff <= edge_ff + 2'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_dist_ff <= LimSq;
         best_x_ff    <= '0;
         best_y_ff    <= '0;
         best_idx_ff  <= '0;
         any_hit_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         out_data_ff  <= '0;
         out_hit_ff   <= 1'b0;
      end else begin
         if (state_ff == B_DIST && step_ff == 6'd3 && 64'(dsq) <= best_dist_ff) begin
            best_dist_ff <= 64'(dsq);
            best_x_ff    <= px_ff;
            best_y_ff    <= py_ff;
            best_idx_ff  <= item_ff.idx;
            any_hit_ff   <= 1'b1;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
            out_hit_ff   <= any_hit_ff;
            out_data_ff  <= any_hit_ff ?
               {6'd0, best_idx_ff, sat24(48'(best_y_ff)), sat24(48'(best_x_ff))} : '0;
            best_dist_ff <= LimSq;
            best_x_ff    <= '0;
            best_y_ff    <= '0;
            best_idx_ff  <= '0;
            any_hit_ff   <= 1'b0;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end
endmodule

/* hdl/ray_box_nearest_hit.sv */
// Top level: configuration registers, front end, queue and edge engine.
// An accepted word is registered in the queue before the engine can pop it.
// Per quad the engine forms the ray end, then per edge the cross products and, on a hit,
// the one-bit-per-cycle divider (not when t is exactly one) and the point and distance;
// disabled quads skip to the finish. The result word is valid in the cycle after it.
// Two quads queue; a waiting result stalls the engine, then the input. Synchronous
// active-high reset clears the queue and nearest-hit state and sets config defaults.
`timescale 1ns / 1ps
module ray_box_nearest_hit #(
   parameter int MAX_BOXES = 1024,
   parameter int FRAC_BITS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [239:0] req_tdata,  // corner0_x, corner0_y .. corner3_y, offset_x, offset_y
   input  logic         req_tuser,  // enabled
   input  logic         req_tlast,  // last_box
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // hit_x, hit_y, hit_object, zero pad
   output logic         rsp_tuser,  // hit_found
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [rbnh_pkg::CsrIdxW-1:0] csr_index,
   input  logic [23:0]  csr_data
);
   import rbnh_pkg::*;

   ray_cfg_type     cfg_ff;
   quad_type        push_data, pop_data;
   logic            push, full, pop, empty;
   back_status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_x    <= '0;
         cfg_ff.start_y    <= '0;
         cfg_ff.dir_x      <= 24'sd256;
         cfg_ff.dir_y      <= '0;
         cfg_ff.ray_length <= 23'd256;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_START_X: cfg_ff.start_x    <= csr_data;
            CSR_START_Y: cfg_ff.start_y    <= csr_data;
            CSR_DIR_X:   cfg_ff.dir_x      <= csr_data;
            CSR_DIR_Y:   cfg_ff.dir_y      <= csr_data;
            CSR_LENGTH:  cfg_ff.ray_length <= csr_data[22:0];
            default: ;
         endcase
      end
   end

   rbnh_front #(.MAX_BOXES(MAX_BOXES)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser, .req_tlast,
      .push, .push_data, .full
   );

   rbnh_queue u_queue (
      .clock, .reset, .push, .push_data, .full, .pop, .pop_data, .empty
   );

   rbnh_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .cfg(cfg_ff), .q_empty(empty), .q_data(pop_data), .q_pop(pop),
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .status
   );

   a_no_hit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("result without hit carries data");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result word present after reset");

   a_rise_from_engine: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(status.emit) && $past(status.busy))
      else $error("result word raised without a finished scene");
endmodule
